@@ hw/rtl/pbq_pkg.sv @@
// ---------------------------------------------------------------------------
// pbq_pkg
// Shared types, constants and helpers of the brightness knob qualifier.
// ---------------------------------------------------------------------------
package pbq_pkg;

   localparam int SAMPLE_W = 12;
   localparam int SUM_W    = 16;
   localparam int LEVEL_W  = 8;
   localparam int COUNT_W  = 4;
   localparam int WINDOW_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // ADC full scale and its reciprocal: floor(p / 4095) == (p * SCALE_RECIP) >> 32
   // for every product p below 2**20.
   localparam logic [SAMPLE_W-1:0] FULL_SCALE  = 12'd4095;
   localparam int                  SCALE_SHIFT = 32;
   localparam logic [20:0]         SCALE_RECIP = 21'd1048833;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] IDX_BRIGHTNESS_MAX     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_DEADBAND           = 3'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_ARM_MARGIN         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] IDX_OFF_THRESHOLD      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] IDX_MIN_ACTIVE         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] IDX_CONFIRM_COUNT      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] IDX_IGNORE_READINGS    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] IDX_INITIAL_BRIGHTNESS = 3'd7;

   // register reset values
   localparam logic [7:0]          BRIGHTNESS_MAX_RST     = 8'd100;
   localparam logic [7:0]          DEADBAND_RST           = 8'd5;
   localparam logic [7:0]          ARM_MARGIN_RST         = 8'd12;
   localparam logic [7:0]          OFF_THRESHOLD_RST      = 8'd2;
   localparam logic [7:0]          MIN_ACTIVE_RST         = 8'd6;
   localparam logic [COUNT_W-1:0]  CONFIRM_COUNT_RST      = 4'd3;
   localparam logic [WINDOW_W-1:0] IGNORE_READINGS_RST    = 16'd300;
   localparam logic [7:0]          INITIAL_BRIGHTNESS_RST = 8'd50;

   typedef struct packed {
      logic [LEVEL_W-1:0]  brightness_max;
      logic [LEVEL_W-1:0]  deadband;
      logic [LEVEL_W-1:0]  arm_margin;
      logic [LEVEL_W-1:0]  off_threshold;
      logic [LEVEL_W-1:0]  min_active;
      logic [COUNT_W-1:0]  confirm_count;
      logic [WINDOW_W-1:0] ignore_readings;
      logic [LEVEL_W-1:0]  initial_brightness;
   } cfg_type;

   // at or below off threshold -> 0, else raised to at least min_active
   function automatic logic [LEVEL_W-1:0] normalize(input logic [LEVEL_W-1:0] b,
                                                    input logic [LEVEL_W-1:0] off_thr,
                                                    input logic [LEVEL_W-1:0] min_act);
      logic [LEVEL_W-1:0] r;
      if (b <= off_thr) begin
         r = '0;
      end else if (b < min_act) begin
         r = min_act;
      end else begin
         r = b;
      end
      return r;
   endfunction

   localparam logic [LEVEL_W-1:0] APPLIED_RST =
      normalize(INITIAL_BRIGHTNESS_RST, OFF_THRESHOLD_RST, MIN_ACTIVE_RST);

endpackage

@@ hw/rtl/pbq_scaler.sv @@
// ---------------------------------------------------------------------------
// pbq_scaler
// Three-stage datapath: group sum -> average -> scaled -> normalized level.
// ---------------------------------------------------------------------------
module pbq_scaler #(
   parameter int SAMPLES_PER_READING = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         sum_valid,
   input  logic [pbq_pkg::SUM_W-1:0]    sum,
   output logic                         sum_free,
   input  pbq_pkg::cfg_type             cfg,
   output logic                         lvl_valid,
   output logic [pbq_pkg::LEVEL_W-1:0]  lvl,
   input  logic                         lvl_free
);

   // floor(x / N) == (x * AVG_RECIP) >> AVG_SHIFT for all 16-bit x, N up to 16
   localparam int          AVG_SHIFT = pbq_pkg::SUM_W + 5;
   localparam int          RECIP_W   = AVG_SHIFT + 1;
   localparam int          AVG_PW    = pbq_pkg::SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] AVG_RECIP =
      RECIP_W'((2 ** AVG_SHIFT) / SAMPLES_PER_READING + 1);

   localparam int SCL_W = pbq_pkg::SAMPLE_W + pbq_pkg::LEVEL_W;
   localparam int LVL_PW = SCL_W + 21;

   logic                          a_valid_ff, b_valid_ff, c_valid_ff;
   logic [pbq_pkg::SAMPLE_W-1:0]  avg_ff, avg_in;
   logic [SCL_W-1:0]              scaled_ff, scaled_in;
   logic [pbq_pkg::LEVEL_W-1:0]   level_ff, level_in;
   logic                          a_free, b_free, c_free;
   logic [AVG_PW-1:0]             avg_prod;
   logic [AVG_PW-AVG_SHIFT-1:0]   avg_quot;
   logic [LVL_PW-1:0]             lvl_prod;

   assign c_free   = !c_valid_ff || lvl_free;
   assign b_free   = !b_valid_ff || c_free;
   assign a_free   = !a_valid_ff || b_free;
   assign sum_free = a_free;

   always_comb begin
      avg_prod = {{RECIP_W{1'b0}}, sum} * {{pbq_pkg::SUM_W{1'b0}}, AVG_RECIP};
      avg_quot = avg_prod[AVG_PW-1:AVG_SHIFT];
      if (avg_quot > {{(AVG_PW-AVG_SHIFT-pbq_pkg::SAMPLE_W){1'b0}}, pbq_pkg::FULL_SCALE}) begin
         avg_in = pbq_pkg::FULL_SCALE;
      end else begin
         avg_in = avg_quot[pbq_pkg::SAMPLE_W-1:0];
      end
   end

   assign scaled_in = {{pbq_pkg::LEVEL_W{1'b0}}, avg_ff}
                    * {{pbq_pkg::SAMPLE_W{1'b0}}, cfg.brightness_max};

   assign lvl_prod = {21'd0, scaled_ff} * {{SCL_W{1'b0}}, pbq_pkg::SCALE_RECIP};
   assign level_in = pbq_pkg::normalize(lvl_prod[pbq_pkg::SCALE_SHIFT +: pbq_pkg::LEVEL_W],
                                        cfg.off_threshold, cfg.min_active);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_free) a_valid_ff <= sum_valid;
         if (b_free) b_valid_ff <= a_valid_ff;
         if (c_free) c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_free && sum_valid) avg_ff    <= avg_in;
      if (b_free && a_valid_ff) scaled_ff <= scaled_in;
      if (c_free && b_valid_ff) level_ff  <= level_in;
   end

   assign lvl_valid = c_valid_ff;
   assign lvl       = level_ff;

endmodule

@@ hw/rtl/pbq_qualifier.sv @@
// ---------------------------------------------------------------------------
// pbq_qualifier
// Boot reference, ignore window, arming and deadband; drives the result register.
// ---------------------------------------------------------------------------
module pbq_qualifier (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         lvl_valid,
   input  logic [pbq_pkg::LEVEL_W-1:0]  lvl,
   output logic                         lvl_free,
   input  pbq_pkg::cfg_type             cfg,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pbq_pkg::LEVEL_W-1:0]  rsp_level,
   output logic [pbq_pkg::LEVEL_W-1:0]  rsp_held_level,
   output logic                         rsp_light_on,
   output logic                         rsp_update,
   output logic                         rsp_armed
);

   localparam int LW = pbq_pkg::LEVEL_W;
   localparam int CW = pbq_pkg::COUNT_W;
   localparam int WW = pbq_pkg::WINDOW_W;

   logic          ref_taken_ff, ref_taken_in;
   logic [LW-1:0] ref_level_ff, ref_level_in;
   logic [WW-1:0] ignore_left_ff, ignore_left_in;
   logic          armed_ff, armed_in;
   logic [LW-1:0] cand_level_ff, cand_level_in;
   logic [CW-1:0] cand_count_ff, cand_count_in;
   logic [LW-1:0] applied_ff, applied_in;
   logic          rsp_valid_ff;
   logic [LW-1:0] rsp_level_ff, rsp_held_ff;
   logic          rsp_update_ff, rsp_armed_ff;
   logic          take, upd, arm;
   logic [LW-1:0] dist_ref, dist_app;

   function automatic logic [LW-1:0] distance(input logic [LW-1:0] a, input logic [LW-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   assign lvl_free = !rsp_valid_ff || !rsp_stall;
   assign take     = lvl_valid && lvl_free;
   assign dist_ref = distance(lvl, ref_level_ff);
   assign dist_app = distance(lvl, applied_ff);

   always_comb begin
      ref_taken_in   = ref_taken_ff;
      ref_level_in   = ref_level_ff;
      ignore_left_in = ignore_left_ff;
      armed_in       = armed_ff;
      cand_level_in  = cand_level_ff;
      cand_count_in  = cand_count_ff;
      applied_in     = applied_ff;
      upd            = 1'b0;
      arm            = 1'b0;
      if (!ref_taken_ff) begin
         // boot reading
         ref_taken_in   = 1'b1;
         ref_level_in   = lvl;
         ignore_left_in = cfg.ignore_readings;
         cand_level_in  = '0;
         cand_count_in  = '0;
         applied_in     = pbq_pkg::normalize(cfg.initial_brightness,
                                             cfg.off_threshold, cfg.min_active);
      end else if (armed_ff) begin
         upd = (dist_app >= cfg.deadband);
      end else if (ignore_left_ff != '0) begin
         ignore_left_in = ignore_left_ff - 1'b1;
      end else if (dist_ref < cfg.arm_margin) begin
         cand_count_in = '0;
      end else begin
         if (lvl == cand_level_ff) begin
            if (cand_count_ff < cfg.confirm_count) cand_count_in = cand_count_ff + 1'b1;
         end else begin
            cand_level_in = lvl;
            cand_count_in = CW'(1);
         end
         arm = (cand_count_in >= cfg.confirm_count);
         // on arming applied takes the level, so the deadband test sees distance 0
         upd = arm && (cfg.deadband == '0);
      end
      if (arm) armed_in = 1'b1;
      if (arm || upd) applied_in = lvl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_taken_ff   <= 1'b0;
         ref_level_ff   <= '0;
         ignore_left_ff <= '0;
         armed_ff       <= 1'b0;
         cand_level_ff  <= '0;
         cand_count_ff  <= '0;
         applied_ff     <= pbq_pkg::APPLIED_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (lvl_free) rsp_valid_ff <= lvl_valid;
         if (take) begin
            ref_taken_ff   <= ref_taken_in;
            ref_level_ff   <= ref_level_in;
            ignore_left_ff <= ignore_left_in;
            armed_ff       <= armed_in;
            cand_level_ff  <= cand_level_in;
            cand_count_ff  <= cand_count_in;
            applied_ff     <= applied_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_level_ff  <= lvl;
         rsp_held_ff   <= applied_in;
         rsp_update_ff <= upd;
         rsp_armed_ff  <= armed_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_held_level = rsp_held_ff;
   assign rsp_light_on   = (rsp_held_ff != '0);
   assign rsp_update     = rsp_update_ff;
   assign rsp_armed      = rsp_armed_ff;

   a_armed_sticky: assert property (@(posedge clock) disable iff (reset)
      armed_ff |=> armed_ff)
      else $error("armed flag dropped");

   a_armed_after_window: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (ref_taken_ff && ignore_left_ff == '0))
      else $error("armed before reference or inside ignore window");

   a_result_has_reference: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ref_taken_ff)
      else $error("result delivered without a boot reference");

endmodule

@@ hw/rtl/pot_brightness_qualifier.sv @@
// ---------------------------------------------------------------------------
// pot_brightness_qualifier
// Averages ADC samples of a brightness knob into readings and qualifies them.
// ---------------------------------------------------------------------------
// Throughput: one sample per cycle while the result path does not stall;
//   one result per group of SAMPLES_PER_READING samples.
// Result path: a result passes the sum register, three multiplier stages
//   and the decision after the edge that accepts the last sample of its group.
// Reset: synchronous; clears the accumulator, pipeline and qualifier state
//   and loads every register with its default. No clearing pass.
module pot_brightness_qualifier #(
   parameter int SAMPLES_PER_READING = 16   // 1 .. 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pbq_pkg::SAMPLE_W-1:0]    req_raw_sample,
   // result output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pbq_pkg::LEVEL_W-1:0]     rsp_level,
   output logic [pbq_pkg::LEVEL_W-1:0]     rsp_held_level,
   output logic                            rsp_light_on,
   output logic                            rsp_update,
   output logic                            rsp_armed,
   // configuration writes
   input  logic                            csr_we,
   input  logic [pbq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pbq_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IDX_W = pbq_pkg::COUNT_W;
   // index of the last sample of a group; the 4-bit index wraps at 16
   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(SAMPLES_PER_READING - 1);

   pbq_pkg::cfg_type             cfg_ff;

   logic [pbq_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [IDX_W-1:0]             index_ff;
   logic                         group_done;
   logic                         accept;

   // completed group sum, waiting for the scaler
   logic                         grp_valid_ff;
   logic [pbq_pkg::SUM_W-1:0]    grp_sum_ff;
   logic                         grp_free;
   logic                         scl_free;

   logic                         lvl_valid;
   logic [pbq_pkg::LEVEL_W-1:0]  lvl;
   logic                         lvl_free;

   // -------------------------------------------------------------------
   // Configuration registers. The user must write them only while idle, so
   // the pipeline sees stable values across one item; not enforced here.
   // -------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness_max     <= pbq_pkg::BRIGHTNESS_MAX_RST;
         cfg_ff.deadband           <= pbq_pkg::DEADBAND_RST;
         cfg_ff.arm_margin         <= pbq_pkg::ARM_MARGIN_RST;
         cfg_ff.off_threshold      <= pbq_pkg::OFF_THRESHOLD_RST;
         cfg_ff.min_active         <= pbq_pkg::MIN_ACTIVE_RST;
         cfg_ff.confirm_count      <= pbq_pkg::CONFIRM_COUNT_RST;
         cfg_ff.ignore_readings    <= pbq_pkg::IGNORE_READINGS_RST;
         cfg_ff.initial_brightness <= pbq_pkg::INITIAL_BRIGHTNESS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pbq_pkg::IDX_BRIGHTNESS_MAX:     cfg_ff.brightness_max     <= csr_wdata[7:0];
            pbq_pkg::IDX_DEADBAND:           cfg_ff.deadband           <= csr_wdata[7:0];
            pbq_pkg::IDX_ARM_MARGIN:         cfg_ff.arm_margin         <= csr_wdata[7:0];
            pbq_pkg::IDX_OFF_THRESHOLD:      cfg_ff.off_threshold      <= csr_wdata[7:0];
            pbq_pkg::IDX_MIN_ACTIVE:         cfg_ff.min_active         <= csr_wdata[7:0];
            pbq_pkg::IDX_CONFIRM_COUNT:      cfg_ff.confirm_count      <= csr_wdata[3:0];
            pbq_pkg::IDX_IGNORE_READINGS:    cfg_ff.ignore_readings    <= csr_wdata[15:0];
            pbq_pkg::IDX_INITIAL_BRIGHTNESS: cfg_ff.initial_brightness <= csr_wdata[7:0];
         endcase
      end
   end

   // -------------------------------------------------------------------
   // Input side: a sample is taken whenever the group register can move on,
   // so the knob stream only stalls behind a stalled result path.
   // -------------------------------------------------------------------
   assign grp_free   = !grp_valid_ff || scl_free;
   assign req_stall  = !grp_free;
   assign accept     = req_valid && grp_free;
   assign group_done = (index_ff == LAST_INDEX);
   // running sum wraps at 16 bits, never reached for a full group
   assign sum_in     = sum_ff + {{(pbq_pkg::SUM_W-pbq_pkg::SAMPLE_W){1'b0}}, req_raw_sample};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         index_ff     <= '0;
         grp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (group_done) begin
               sum_ff   <= '0;
               index_ff <= '0;
            end else begin
               sum_ff   <= sum_in;
               index_ff <= index_ff + 1'b1;
            end
         end
         if (grp_free) grp_valid_ff <= accept && group_done;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && group_done) grp_sum_ff <= sum_in;
   end

   // -------------------------------------------------------------------
   // Average, scale to brightness and normalise: three registered stages,
   // one multiplier in each.
   // -------------------------------------------------------------------
   pbq_scaler #(
      .SAMPLES_PER_READING (SAMPLES_PER_READING)
   ) u_scaler (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (grp_valid_ff),
      .sum       (grp_sum_ff),
      .sum_free  (scl_free),
      .cfg       (cfg_ff),
      .lvl_valid (lvl_valid),
      .lvl       (lvl),
      .lvl_free  (lvl_free)
   );

   // -------------------------------------------------------------------
   // Boot reference, ignore window, arming and deadband; the result
   // register lives here and holds while the consumer stalls.
   // -------------------------------------------------------------------
   pbq_qualifier u_qualifier (
      .clock          (clock),
      .reset          (reset),
      .lvl_valid      (lvl_valid),
      .lvl            (lvl),
      .lvl_free       (lvl_free),
      .cfg            (cfg_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_level      (rsp_level),
      .rsp_held_level (rsp_held_level),
      .rsp_light_on   (rsp_light_on),
      .rsp_update     (rsp_update),
      .rsp_armed      (rsp_armed)
   );

endmodule

@@ tb/pot_brightness_qualifier_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pot_brightness_qualifier_tb
// Self-checking bench for the knob qualifier. A directed plan walks boot,
// the ignore window, candidate tracking, arming and the level extremes.
// Random phases follow: each may rewrite registers while idle and then feeds
// whole groups of samples. A local predictor of the averaging and
// qualification produces one expected result per group. Both handshakes
// idle at random.
// ---------------------------------------------------------------------------
module pot_brightness_qualifier_tb;

   localparam int SAMPLE_W   = pbq_pkg::SAMPLE_W;
   localparam int SUM_W      = pbq_pkg::SUM_W;
   localparam int LEVEL_W    = pbq_pkg::LEVEL_W;
   localparam int COUNT_W    = pbq_pkg::COUNT_W;
   localparam int WINDOW_W   = pbq_pkg::WINDOW_W;
   localparam int CSR_IDX_W  = pbq_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = pbq_pkg::CSR_DATA_W;

   localparam int GROUP          = 16;        // samples per reading
   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 8;
   localparam int DRAIN_CYCLES   = 12;        // margin over the result latency
   localparam int TAIL_CYCLES    = 20;
   localparam int RANDOM_SAMPLES = 512;
   localparam int CYCLE_LIMIT    = 400000;

   // one result item of the block
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [LEVEL_W-1:0] held_level;
      logic               light_on;
      logic               update;
      logic               armed;
   } reading_type;

   typedef enum logic [1:0] {ROW_WRITE, ROW_READING, ROW_CHECKED} row_kind_type;

   // one row of the directed plan: a register write or a whole group of
   // equal samples, with the result typed in where it is obvious
   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] data;
      logic [SAMPLE_W-1:0]   sample;
      reading_type           want;
   } plan_row_type;

   // DUT connections; every input is known from time zero
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_raw_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall      = 1'b0;
   logic [LEVEL_W-1:0]    rsp_level;
   logic [LEVEL_W-1:0]    rsp_held_level;
   logic                  rsp_light_on;
   logic                  rsp_update;
   logic                  rsp_armed;
   logic                  csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   // predictor state: register copy and qualifier state
   pbq_pkg::cfg_type      cfg;
   logic [SUM_W-1:0]      acc_sum;
   logic [COUNT_W-1:0]    acc_count;
   logic                  ref_taken;
   logic [LEVEL_W-1:0]    ref_level;
   logic [WINDOW_W-1:0]   ignore_left;
   logic                  is_armed;
   logic [LEVEL_W-1:0]    cand_level;
   logic [COUNT_W-1:0]    cand_count;
   logic [LEVEL_W-1:0]    applied;

   reading_type           pending [$];     // readings still to come out
   plan_row_type          plan [$];
   reading_type           seen_want;

   int                    errors        = 0;
   int                    samples_sent  = 0;
   int                    readings_seen = 0;
   int                    writes_done   = 0;
   int                    cycle_count   = 0;
   int                    stall_left    = 0;
   int                    stall_pick;
   bit                    no_gaps       = 1'b0;
   bit                    writing       = 1'b0;

   pot_brightness_qualifier #(
      .SAMPLES_PER_READING(GROUP)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_raw_sample(req_raw_sample),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_level     (rsp_level),
      .rsp_held_level(rsp_held_level),
      .rsp_light_on  (rsp_light_on),
      .rsp_update    (rsp_update),
      .rsp_armed     (rsp_armed),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // off threshold squelch, then lift to the minimum active level
   function automatic logic [LEVEL_W-1:0] squelch(input logic [LEVEL_W-1:0] b);
      if (b <= cfg.off_threshold) return '0;
      if (b < cfg.min_active) return cfg.min_active;
      return b;
   endfunction

   function automatic logic [LEVEL_W-1:0] span(input logic [LEVEL_W-1:0] a,
                                                input logic [LEVEL_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      case (idx)
         pbq_pkg::IDX_BRIGHTNESS_MAX:     cfg.brightness_max     = d[7:0];
         pbq_pkg::IDX_DEADBAND:           cfg.deadband           = d[7:0];
         pbq_pkg::IDX_ARM_MARGIN:         cfg.arm_margin         = d[7:0];
         pbq_pkg::IDX_OFF_THRESHOLD:      cfg.off_threshold      = d[7:0];
         pbq_pkg::IDX_MIN_ACTIVE:         cfg.min_active         = d[7:0];
         pbq_pkg::IDX_CONFIRM_COUNT:      cfg.confirm_count      = d[COUNT_W-1:0];
         pbq_pkg::IDX_IGNORE_READINGS:    cfg.ignore_readings    = d[WINDOW_W-1:0];
         pbq_pkg::IDX_INITIAL_BRIGHTNESS: cfg.initial_brightness = d[7:0];
         default: ;
      endcase
   endtask

   // accumulate one sample; on the last of a group, qualify the reading
   task automatic predict_sample(input logic [SAMPLE_W-1:0] v, output bit done,
                                 output reading_type r);
      logic [SUM_W-1:0]   avg;
      int                 scaled;
      logic [LEVEL_W-1:0] lvl;
      bit                 go;
      bit                 moved;
      done      = 1'b0;
      r         = '0;
      acc_sum   = acc_sum + SUM_W'(v);
      acc_count = acc_count + 1'b1;
      if (acc_count == '0) begin
         done    = 1'b1;
         avg     = acc_sum / SUM_W'(GROUP);
         acc_sum = '0;
         scaled  = (int'(avg) * int'(cfg.brightness_max)) / int'(pbq_pkg::FULL_SCALE);
         lvl     = squelch(scaled[7:0]);
         moved   = 1'b0;
         if (!ref_taken) begin
            // boot reading: reference, ignore window, fresh applied level
            ref_taken   = 1'b1;
            ref_level   = lvl;
            ignore_left = cfg.ignore_readings;
            cand_level  = '0;
            cand_count  = '0;
            applied     = squelch(cfg.initial_brightness);
         end else begin
            go = is_armed;
            if (!is_armed) begin
               if (ignore_left != '0) begin
                  ignore_left = ignore_left - 1'b1;
               end else if (span(lvl, ref_level) < cfg.arm_margin) begin
                  cand_count = '0;
               end else begin
                  if (lvl == cand_level) begin
                     if (cand_count < cfg.confirm_count) cand_count = cand_count + 1'b1;
                  end else begin
                     cand_level = lvl;
                     cand_count = 4'd1;
                  end
                  if (cand_count >= cfg.confirm_count) begin
                     is_armed = 1'b1;
                     applied  = lvl;
                     go       = 1'b1;
                  end
               end
            end
            if (go && span(lvl, applied) >= cfg.deadband) begin
               applied = lvl;
               moved   = 1'b1;
            end
         end
         r.level      = lvl;
         r.held_level = applied;
         r.light_on   = (applied != '0);
         r.update     = moved;
         r.armed      = is_armed;
      end
   endtask

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // mostly back to back, sometimes a short pause, now and then a long one
   function automatic int pick_gap();
      int p;
      if (no_gaps) return 0;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [SAMPLE_W-1:0] clip12(input int x);
      if (x < 0) return '0;
      if (x > int'(pbq_pkg::FULL_SCALE)) return pbq_pkg::FULL_SCALE;
      return x[SAMPLE_W-1:0];
   endfunction

   task automatic close_writes();
      if (writing) begin
         csr_we  <= 1'b0;
         writing  = 1'b0;
      end
   endtask

   // register writes only while the block is empty
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      if (!writing) begin
         req_valid <= 1'b0;
         while (pending.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
         writing = 1'b1;
      end
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      apply_reg(idx, d);
      writes_done++;
   endtask

   // hand one sample over; valid stays high if the next item follows at once
   task automatic issue_sample(input logic [SAMPLE_W-1:0] v, input bit use_typed,
                               input reading_type typed);
      int          gap;
      bit          done;
      reading_type r;
      gap = pick_gap();
      close_writes();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_raw_sample <= v;
      do @(posedge clock); while (req_stall);
      predict_sample(v, done, r);
      if (done) pending.push_back(use_typed ? typed : r);
      samples_sent++;
   endtask

   // random value for a register, extremes weighted in; stray upper data
   // bits are thrown in half the time since the register must drop them
   function automatic logic [CSR_DATA_W-1:0] reg_value(input logic [CSR_IDX_W-1:0] idx);
      int                    p;
      logic [CSR_DATA_W-1:0] v;
      p = $urandom_range(0, 9);
      v = CSR_DATA_W'($urandom_range(0, 255));
      case (idx)
         pbq_pkg::IDX_BRIGHTNESS_MAX:
            v = (p == 0) ? 16'd0 : (p == 1) ? 16'd255 : CSR_DATA_W'($urandom_range(1, 255));
         pbq_pkg::IDX_DEADBAND:
            v = (p < 2) ? 16'd0 : (p == 2) ? 16'd255 : CSR_DATA_W'($urandom_range(1, 24));
         pbq_pkg::IDX_OFF_THRESHOLD:
            v = (p == 0) ? 16'd255 : (p == 1) ? 16'd0 : CSR_DATA_W'($urandom_range(0, 12));
         pbq_pkg::IDX_MIN_ACTIVE:
            v = (p == 0) ? 16'd255 : (p == 1) ? 16'd0 : CSR_DATA_W'($urandom_range(0, 40));
         pbq_pkg::IDX_CONFIRM_COUNT:
            v = (p == 0) ? 16'd0 : (p == 1) ? 16'd15 : CSR_DATA_W'($urandom_range(1, 15));
         pbq_pkg::IDX_IGNORE_READINGS:
            v = (p == 0) ? 16'd0 : (p == 1) ? 16'hFFFF : CSR_DATA_W'($urandom_range(0, 65535));
         default: ;
      endcase
      if ($urandom_range(0, 1) == 1) begin
         if (idx == pbq_pkg::IDX_CONFIRM_COUNT) v[15:4] = 12'($urandom);
         else if (idx != pbq_pkg::IDX_IGNORE_READINGS) v[15:8] = 8'($urandom);
      end
      return v;
   endfunction

   // receiver: runs of stall and of free flow, a few long ones of each
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 25) begin
            rsp_stall  <= 1'b1;
            stall_left  = $urandom_range(0, 2);
         end else if (stall_pick < 31) begin
            rsp_stall  <= 1'b1;
            stall_left  = $urandom_range(10, 30);
         end else if (stall_pick < 88) begin
            rsp_stall  <= 1'b0;
            stall_left  = $urandom_range(0, 6);
         end else begin
            rsp_stall  <= 1'b0;
            stall_left  = $urandom_range(40, 150);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         readings_seen++;
         if (pending.size() == 0) begin
            $error("result with no reading pending: level %0d held_level %0d",
                   rsp_level, rsp_held_level);
            errors++;
         end else begin
            seen_want = pending.pop_front();
            check_field("level", seen_want.level, rsp_level);
            check_field("held_level", seen_want.held_level, rsp_held_level);
            check_field("light_on", 8'(seen_want.light_on), 8'(rsp_light_on));
            check_field("update", 8'(seen_want.update), 8'(rsp_update));
            check_field("armed", 8'(seen_want.armed), 8'(rsp_armed));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directed plan helpers
   // ---------------------------------------------------------------------

   function automatic void add_write(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] d);
      plan_row_type row;
      row.kind    = ROW_WRITE;
      row.reg_idx = idx;
      row.data    = d;
      row.sample  = '0;
      row.want    = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_reading(input logic [SAMPLE_W-1:0] s);
      plan_row_type row;
      row.kind    = ROW_READING;
      row.reg_idx = '0;
      row.data    = '0;
      row.sample  = s;
      row.want    = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_checked(input logic [SAMPLE_W-1:0] s, input logic [7:0] lvl,
                                       input logic [7:0] held, input logic on,
                                       input logic upd, input logic arm);
      plan_row_type row;
      row.kind    = ROW_CHECKED;
      row.reg_idx = '0;
      row.data    = '0;
      row.sample  = s;
      row.want    = '{level: lvl, held_level: held, light_on: on, update: upd, armed: arm};
      plan.push_back(row);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type         row;
      logic [SAMPLE_W-1:0]  hold;
      logic [SAMPLE_W-1:0]  v;
      logic [CSR_IDX_W-1:0] idx;
      int                   random_sent;
      int                   n_read;
      int                   n_writes;
      int                   pick;

      // predictor starts from the register defaults
      cfg.brightness_max     = pbq_pkg::BRIGHTNESS_MAX_RST;
      cfg.deadband           = pbq_pkg::DEADBAND_RST;
      cfg.arm_margin         = pbq_pkg::ARM_MARGIN_RST;
      cfg.off_threshold      = pbq_pkg::OFF_THRESHOLD_RST;
      cfg.min_active         = pbq_pkg::MIN_ACTIVE_RST;
      cfg.confirm_count      = pbq_pkg::CONFIRM_COUNT_RST;
      cfg.ignore_readings    = pbq_pkg::IGNORE_READINGS_RST;
      cfg.initial_brightness = pbq_pkg::INITIAL_BRIGHTNESS_RST;
      acc_sum     = '0;
      acc_count   = '0;
      ref_taken   = 1'b0;
      ref_level   = '0;
      ignore_left = '0;
      is_armed    = 1'b0;
      cand_level  = '0;
      cand_count  = '0;
      applied     = squelch(cfg.initial_brightness);

      // boot with a short window and an initial level that squelches to off
      add_write(pbq_pkg::IDX_IGNORE_READINGS, 16'd2);
      add_write(pbq_pkg::IDX_INITIAL_BRIGHTNESS, 16'd1);
      add_checked(12'd4095, 8'd100, 8'd0, 1'b0, 1'b0, 1'b0);
      add_checked(12'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      add_checked(12'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
      // writes after boot leave the open window and applied level alone
      add_write(pbq_pkg::IDX_IGNORE_READINGS, 16'hFFFF);
      add_write(pbq_pkg::IDX_INITIAL_BRIGHTNESS, 16'd255);
      add_write(pbq_pkg::IDX_ARM_MARGIN, 16'd12);
      // too close to the reference, then candidate builds, changes, clears
      add_reading(12'd4095);
      add_reading(12'd2048);
      add_reading(12'd2048);
      add_reading(12'd1024);
      add_reading(12'd4000);
      add_reading(12'd1024);
      add_reading(12'd1024);
      // zero confirm count arms on the next qualifying reading; zero
      // deadband makes that same reading an update
      add_write(pbq_pkg::IDX_CONFIRM_COUNT, 16'd0);
      add_write(pbq_pkg::IDX_DEADBAND, 16'd0);
      add_reading(12'd1024);
      add_write(pbq_pkg::IDX_DEADBAND, 16'd255);
      add_reading(12'd0);
      // deadband edge: a step of exactly 5 moves, a step of 4 does not
      add_write(pbq_pkg::IDX_DEADBAND, 16'd5);
      add_reading(12'd1229);
      add_reading(12'd1393);
      // zero full scale forces level 0
      add_write(pbq_pkg::IDX_BRIGHTNESS_MAX, 16'd0);
      add_checked(12'd4095, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1);
      // full scale, no squelch, minimum lifted to the top
      add_write(pbq_pkg::IDX_BRIGHTNESS_MAX, 16'd255);
      add_write(pbq_pkg::IDX_OFF_THRESHOLD, 16'd0);
      add_write(pbq_pkg::IDX_MIN_ACTIVE, 16'd255);
      add_checked(12'd4095, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
      add_checked(12'd16, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1);
      add_checked(12'd17, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1);
      // highest off threshold squelches everything
      add_write(pbq_pkg::IDX_OFF_THRESHOLD, 16'd255);
      add_checked(12'd4095, 8'd0, 8'd0, 1'b0, 1'b1, 1'b1);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < plan.size(); n++) begin
         row = plan[n];
         if (row.kind == ROW_WRITE) begin
            write_reg(row.reg_idx, row.data);
         end else begin
            for (int k = 0; k < GROUP; k++) begin
               issue_sample(row.sample, row.kind == ROW_CHECKED, row.want);
            end
         end
      end

      // random phases: optional register changes while idle, then a few
      // whole groups; most groups are steady or jittered around a level so
      // that deadband and squelch decisions are hit, the rest is noise
      random_sent = 0;
      while (random_sent < RANDOM_SAMPLES) begin
         if ($urandom_range(0, 3) == 0) begin
            write_reg(pbq_pkg::IDX_BRIGHTNESS_MAX, 16'(pbq_pkg::BRIGHTNESS_MAX_RST));
            write_reg(pbq_pkg::IDX_OFF_THRESHOLD, 16'(pbq_pkg::OFF_THRESHOLD_RST));
            write_reg(pbq_pkg::IDX_MIN_ACTIVE, 16'(pbq_pkg::MIN_ACTIVE_RST));
         end
         n_writes = $urandom_range(0, 3);
         repeat (n_writes) begin
            idx = CSR_IDX_W'($urandom_range(0, 7));
            write_reg(idx, reg_value(idx));
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         hold    = SAMPLE_W'($urandom_range(0, 4095));
         n_read  = $urandom_range(2, 6);
         repeat (n_read) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               hold = clip12(int'(hold) + int'($urandom_range(0, 600)) - 300);
            end else if (pick < 30) begin
               hold = SAMPLE_W'($urandom_range(0, 4095));
            end
            pick = $urandom_range(0, 99);
            for (int k = 0; k < GROUP; k++) begin
               if (pick < 60) begin
                  v = hold;
               end else if (pick < 85) begin
                  v = clip12(int'(hold) + int'($urandom_range(0, 80)) - 40);
               end else begin
                  v = SAMPLE_W'($urandom);
               end
               issue_sample(v, 1'b0, '0);
               random_sent++;
            end
         end
      end

      close_writes();
      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d samples in %0d directed rows and random phases, %0d readings compared",
               samples_sent, plan.size(), readings_seen);
      $display("%0d register writes across scaling, squelch, deadband and arming settings",
               writes_done);
      if (errors == 0) begin
         $display("pot_brightness_qualifier verification clean");
      end else begin
         $display("pot_brightness_qualifier verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("pot_brightness_qualifier verification failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/pbq_pkg.sv
hw/rtl/pbq_scaler.sv
hw/rtl/pbq_qualifier.sv
hw/rtl/pot_brightness_qualifier.sv
tb/pot_brightness_qualifier_tb.sv
